>>> hdl/stereo_linear_resampler_core_assert.svh
// Assertion macros shared by the resampler's checker.
// Needs clk and rst in scope where a macro is used.
`ifndef STEREO_LINEAR_RESAMPLER_CORE_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_CORE_ASSERT_SVH

// Implication whose consequent is checked on the next cycle, ignored while in reset.
`define SRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("resampler check failed");

// Implication whose consequent is checked on the next cycle, also live across reset.
`define SRL_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("resampler reset check failed");

`endif

>>> hdl/srl_pkg.sv
// Shared types and constants of the stereo linear resampler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package srl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_RUN_DEF   = 8;
  localparam int SAMPLE_W      = 16;
  localparam int RATIO_W       = 18;
  localparam int DATA_W        = 32;
  localparam int APB_AW        = 3;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd65536;

  // Register index, taken from paddr[2].
  localparam logic REG_STEP_RATIO = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // Control that travels alongside an interpolation through the lanes.
  typedef struct packed {
    logic valid;
    logic last;
  } issue_ctl_t;

endpackage

>>> hdl/srl_lane.sv
// One channel of the interpolator: held + (new - held) * pos, truncated toward zero.
// Two register stages; depends on srl_pkg.
`timescale 1ns / 1ps

module srl_lane #(
  parameter int FRAC_BITS = srl_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [srl_pkg::SAMPLE_W-1:0] held,
  input  logic signed [srl_pkg::SAMPLE_W-1:0] fresh,
  input  logic        [FRAC_BITS-1:0]         pos,
  output logic signed [srl_pkg::SAMPLE_W-1:0] y
);

  localparam int SW     = srl_pkg::SAMPLE_W;
  localparam int PROD_W = FRAC_BITS + SW + 2;
  localparam logic signed [PROD_W-1:0] BIAS = {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  logic signed [SW:0]        diff;
  logic signed [SW-1:0]      a1;
  logic        [FRAC_BITS-1:0] pos1;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SW-1:0]      a2;
  logic signed [PROD_W-1:0]  mul_a;
  logic signed [PROD_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  base;
  logic signed [PROD_W-1:0]  sum;
  logic signed [PROD_W-1:0]  rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= {fresh[SW-1], fresh} - {held[SW-1], held};
      a1   <= held;
      pos1 <= pos;
      prod <= mul_a * mul_b;
      a2   <= a1;
    end
  end

  assign mul_a = PROD_W'(diff);
  assign mul_b = $signed({{(PROD_W-FRAC_BITS){1'b0}}, pos1});
  assign base  = $signed({{2{a2[SW-1]}}, a2, {FRAC_BITS{1'b0}}});
  assign sum   = base + prod;
  // bias negative sums so the shift truncates toward zero
  assign rnd   = sum + (sum[PROD_W-1] ? BIAS : '0);
  assign y     = rnd[FRAC_BITS+SW-1:FRAC_BITS];

endmodule

>>> hdl/srl_merge.sv
// Merge stage: joins the two lane results into one output beat with its last flag.
// Owns the pipeline advance and the output register; depends on srl_pkg.
`timescale 1ns / 1ps

module srl_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  srl_pkg::issue_ctl_t                 issue,
  input  logic signed [srl_pkg::SAMPLE_W-1:0] y_left,
  input  logic signed [srl_pkg::SAMPLE_W-1:0] y_right,
  output logic                                adv,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic                                m_tlast,
  output logic        [srl_pkg::DATA_W-1:0]   m_tdata
);

  srl_pkg::issue_ctl_t ctl1;
  srl_pkg::issue_ctl_t ctl2;

  // the whole pipeline holds while a beat waits at the output
  assign adv = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1     <= '0;
      ctl2     <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      ctl1     <= issue;
      ctl2     <= ctl1;
      m_tvalid <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tlast <= ctl2.last;
      m_tdata <= {y_right, y_left};
    end
  end

endmodule

>>> hdl/srl_seq.sv
// Run sequencer: takes input pairs, walks the fractional position and issues
// one interpolation per cycle to both lanes while the pipeline advances. Depends on srl_pkg.
`timescale 1ns / 1ps

module srl_seq #(
  parameter int FRAC_BITS = srl_pkg::FRAC_BITS_DEF,
  parameter int MAX_RUN   = srl_pkg::MAX_RUN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic        [srl_pkg::RATIO_W-1:0]  ratio,
  input  logic                                adv,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [srl_pkg::SAMPLE_W-1:0] in_left,
  input  logic signed [srl_pkg::SAMPLE_W-1:0] in_right,
  output srl_pkg::issue_ctl_t                 issue,
  output logic signed [srl_pkg::SAMPLE_W-1:0] held_left_o,
  output logic signed [srl_pkg::SAMPLE_W-1:0] held_right_o,
  output logic signed [srl_pkg::SAMPLE_W-1:0] new_left_o,
  output logic signed [srl_pkg::SAMPLE_W-1:0] new_right_o,
  output logic        [FRAC_BITS-1:0]         pos_o
);

  localparam int SW    = srl_pkg::SAMPLE_W;
  localparam int RW    = srl_pkg::RATIO_W;
  localparam int POS_W = ((FRAC_BITS + 1 > RW) ? FRAC_BITS + 1 : RW) + 1;
  localparam int CNT_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [POS_W-1:0] ONE      = POS_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_RUN - 1);

  srl_pkg::seq_state_t state, state_next;
  logic              held_valid, held_valid_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic signed [SW-1:0] held_left, held_left_next;
  logic signed [SW-1:0] held_right, held_right_next;
  logic signed [SW-1:0] new_left, new_left_next;
  logic signed [SW-1:0] new_right, new_right_next;

  logic [POS_W-1:0] ratio_ext;
  logic [POS_W-1:0] pos_sum;
  logic             pass;
  logic             run_last;

  assign ratio_ext = POS_W'(ratio);
  assign pass      = (ratio_ext == ONE);
  assign pos_sum   = pos + ratio_ext;
  assign run_last  = (pos_sum >= ONE) || (cnt == LAST_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= srl_pkg::ST_IDLE;
      held_valid <= 1'b0;
      pos        <= '0;
      cnt        <= '0;
      held_left  <= '0;
      held_right <= '0;
    end else begin
      state      <= state_next;
      held_valid <= held_valid_next;
      pos        <= pos_next;
      cnt        <= cnt_next;
      held_left  <= held_left_next;
      held_right <= held_right_next;
    end
  end

  always_ff @(posedge clk) begin
    new_left  <= new_left_next;
    new_right <= new_right_next;
  end

  always_comb begin
    state_next      = state;
    held_valid_next = held_valid;
    pos_next        = pos;
    cnt_next        = cnt;
    held_left_next  = held_left;
    held_right_next = held_right;
    new_left_next   = new_left;
    new_right_next  = new_right;
    in_ready        = 1'b0;
    issue           = '0;
    held_left_o     = held_left;
    held_right_o    = held_right;
    new_left_o      = new_left;
    new_right_o     = new_right;
    pos_o           = pos[FRAC_BITS-1:0];

    unique case (state)
      srl_pkg::ST_IDLE: begin
        in_ready = adv;
        if (in_valid && adv) begin
          new_left_next  = in_left;
          new_right_next = in_right;
          if (pass) begin
            // straight through: interpolate at position zero from the new pair
            issue.valid     = 1'b1;
            issue.last      = 1'b1;
            held_left_o     = in_left;
            held_right_o    = in_right;
            new_left_o      = in_left;
            new_right_o     = in_right;
            pos_o           = '0;
            held_left_next  = in_left;
            held_right_next = in_right;
            held_valid_next = 1'b1;
          end else if (!held_valid) begin
            held_left_next  = in_left;
            held_right_next = in_right;
            held_valid_next = 1'b1;
          end else if (pos >= ONE) begin
            // no result: drop one whole sample from the position
            pos_next        = pos - ONE;
            held_left_next  = in_left;
            held_right_next = in_right;
          end else begin
            cnt_next   = '0;
            state_next = srl_pkg::ST_RUN;
          end
        end
      end
      srl_pkg::ST_RUN: begin
        if (adv) begin
          issue.valid = 1'b1;
          issue.last  = run_last;
          pos_next    = pos_sum;
          cnt_next    = cnt + CNT_W'(1);
          if (run_last) begin
            if (pos_sum >= ONE) begin
              pos_next = pos_sum - ONE;
            end
            held_left_next  = new_left;
            held_right_next = new_right;
            state_next      = srl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = srl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/stereo_linear_resampler_core.sv
// Stereo linear-interpolation resampler, one input pair in, up to MAX_RUN pairs out.
// Item flow: an input beat is taken only while the sequencer is idle. At a ratio of one
// its single result is issued in that same cycle. Otherwise, if the beat produces results,
// the sequencer then issues one interpolation per cycle while the output does not stall
// (one for each output beat, at most MAX_RUN), and takes no new beat until the run ends.
// A beat that gives no result is not followed by a run.
// The sequencer's single issue slot per cycle sets this pace.
// A result passes the lane registers and the merge output register on its way to the
// master side; a beat waiting at the output holds the whole pipeline, so neither issue
// nor input moves until it is taken. Two lanes (left, right) each interpolate with one
// multiplier; a merge stage packs them into a beat.
// step_ratio lives at APB byte address 0 and must be written while idle.
`timescale 1ns / 1ps

module stereo_linear_resampler_core #(
  parameter int FRAC_BITS = srl_pkg::FRAC_BITS_DEF,
  parameter int MAX_RUN   = srl_pkg::MAX_RUN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [srl_pkg::DATA_W-1:0]  s_tdata,   // [15:0] left_in, [31:16] right_in
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [srl_pkg::DATA_W-1:0]  m_tdata,   // [15:0] left_out, [31:16] right_out
  output logic                        m_tlast,   // last_of_run
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srl_pkg::APB_AW-1:0]  paddr,
  input  logic [srl_pkg::DATA_W-1:0]  pwdata,
  output logic [srl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int SW = srl_pkg::SAMPLE_W;

  logic [srl_pkg::RATIO_W-1:0] step_ratio;
  logic                        reg_hit;
  logic                        adv;
  srl_pkg::issue_ctl_t         issue;
  logic signed [SW-1:0]        held_left, held_right, new_left, new_right;
  logic        [FRAC_BITS-1:0] pos;
  logic signed [SW-1:0]        y_left, y_right;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == srl_pkg::REG_STEP_RATIO);
  assign prdata  = reg_hit ? srl_pkg::DATA_W'(step_ratio) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= srl_pkg::RATIO_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      step_ratio <= pwdata[srl_pkg::RATIO_W-1:0];
    end
  end

  srl_seq #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_RUN   (MAX_RUN)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .ratio        (step_ratio),
    .adv          (adv),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_left      ($signed(s_tdata[SW-1:0])),
    .in_right     ($signed(s_tdata[2*SW-1:SW])),
    .issue        (issue),
    .held_left_o  (held_left),
    .held_right_o (held_right),
    .new_left_o   (new_left),
    .new_right_o  (new_right),
    .pos_o        (pos)
  );

  srl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_left (
    .clk   (clk),
    .en    (adv),
    .held  (held_left),
    .fresh (new_left),
    .pos   (pos),
    .y     (y_left)
  );

  srl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_right (
    .clk   (clk),
    .en    (adv),
    .held  (held_right),
    .fresh (new_right),
    .pos   (pos),
    .y     (y_right)
  );

  srl_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .y_left   (y_left),
    .y_right  (y_right),
    .adv      (adv),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
  );

endmodule

>>> hdl/srl_checker.sv
// Port-level checks for the resampler, bound onto the top level.
// Depends on srl_pkg and stereo_linear_resampler_core_assert.svh.
`timescale 1ns / 1ps
`include "stereo_linear_resampler_core_assert.svh"

module srl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [srl_pkg::DATA_W-1:0]  m_tdata,
  input logic                        m_tlast,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic                        pready,
  input logic [srl_pkg::APB_AW-1:0]  paddr,
  input logic [srl_pkg::DATA_W-1:0]  pwdata,
  input logic [srl_pkg::DATA_W-1:0]  prdata
);

  localparam int RW = srl_pkg::RATIO_W;

  logic ratio_sel;
  logic ratio_wr;

  assign ratio_sel = (paddr[2] == srl_pkg::REG_STEP_RATIO);
  assign ratio_wr  = psel && penable && pwrite && pready && ratio_sel;

  // a stalled beat stays offered
  `SRL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  // a stalled beat keeps its payload
  `SRL_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  // reset flushes the pipeline: no beat is offered straight after reset
  `SRL_ASSERT_ALWAYS(a_rst_flush, rst, !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
  // a ratio write reads back on the next cycle
  `SRL_ASSERT_NEXT(a_ratio_rb, ratio_wr, !ratio_sel || prdata[RW-1:0] == $past(pwdata[RW-1:0]))

endmodule

bind stereo_linear_resampler_core srl_checker u_srl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .pready   (pready),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

>>> dv/tb_top.sv
// Self-checking testbench for stereo_linear_resampler_core: random and directed stereo
// beats, a built-in interpolation predictor and an in-order scoreboard.
// Depends on hdl/srl_pkg.sv and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int RUN_CAP       = srl_pkg::MAX_RUN_DEF;
  localparam longint UNITY     = longint'(1) << srl_pkg::FRAC_BITS_DEF;
  localparam logic [srl_pkg::RATIO_W-1:0] RATIO_UNITY = 18'd65536;
  localparam logic [srl_pkg::APB_AW-1:0]  STEP_RATIO_ADDR = 3'd0;
  localparam logic [srl_pkg::APB_AW-1:0]  SPARE_ADDR      = 3'd4;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } stereo_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [srl_pkg::DATA_W-1:0]    s_tdata = '0;   // [15:0] left_in, [31:16] right_in
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [srl_pkg::DATA_W-1:0]    m_tdata;        // [15:0] left_out, [31:16] right_out
  logic                          m_tlast;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [srl_pkg::APB_AW-1:0]    paddr = '0;
  logic [srl_pkg::DATA_W-1:0]    pwdata = '0;
  logic [srl_pkg::DATA_W-1:0]    prdata;
  logic                          pready;

  logic [31:0]  pairs_to_send[$];
  stereo_beat_t expected_beats[$];
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           mismatches = 0;
  int           stall_cycles = 0;
  logic [31:0]  prev_random = '0;
  stereo_beat_t want_beat, got_beat;

  // Predictor state
  logic [srl_pkg::RATIO_W-1:0] step_ratio_q = srl_pkg::RATIO_RESET;
  logic signed [15:0]          held_l = '0;
  logic signed [15:0]          held_r = '0;
  bit                          pair_held = 1'b0;
  longint                      position = 0;

  stereo_linear_resampler_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Weighted mix of two samples, truncated toward zero.
  function automatic logic [15:0] blend(longint a, longint b, longint frac);
    longint acc, mag;
    acc = a * (UNITY - frac) + b * frac;
    mag = ((acc < 0) ? -acc : acc) >> srl_pkg::FRAC_BITS_DEF;
    if (acc < 0) mag = -mag;
    return mag[15:0];
  endfunction

  function automatic void resample_pair(logic signed [15:0] l, logic signed [15:0] r);
    stereo_beat_t b;
    int           n;
    longint       next_pos;
    n = 0;
    if (step_ratio_q == RATIO_UNITY) begin
      b.left  = l;
      b.right = r;
      b.last  = 1'b1;
      expected_beats.push_back(b);
    end else if (pair_held) begin
      while (position < UNITY && n < RUN_CAP) begin
        next_pos = position + longint'(step_ratio_q);
        b.left   = blend(held_l, l, position);
        b.right  = blend(held_r, r, position);
        b.last   = !(next_pos < UNITY && n + 1 < RUN_CAP);
        expected_beats.push_back(b);
        position = next_pos;
        n++;
      end
      if (position >= UNITY) position -= UNITY;
    end
    held_l    = l;
    held_r    = r;
    pair_held = 1'b1;
  endfunction

  function automatic logic [15:0] boundary_sample(int k);
    case (k)
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Mostly uniform noise, some boundary values, some slowly moving audio.
  function automatic logic [31:0] random_pair();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65)
      prev_random = $urandom();
    else if (pick < 85)
      prev_random = {boundary_sample($urandom_range(4)), boundary_sample($urandom_range(4))};
    else
      prev_random = {prev_random[31:16] + 16'($urandom_range(2047)) - 16'd1024,
                     prev_random[15:0] + 16'($urandom_range(2047)) - 16'd1024};
    return prev_random;
  endfunction

  task automatic note_mismatch(input string what, input stereo_beat_t want,
                               input stereo_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s: expected L=%h R=%h last=%b, got L=%h R=%h last=%b", $realtime,
               what, want.left, want.right, want.last, got.left, got.right, got.last);
  endtask

  task automatic apb_write(input logic [srl_pkg::APB_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == srl_pkg::REG_STEP_RATIO)
      step_ratio_q = data[srl_pkg::RATIO_W-1:0];
    @(negedge clk);
  endtask

  // Wait until every beat is in and out, then let the pipeline settle.
  task automatic drain();
    while (pairs_to_send.size() != 0 || s_tvalid || expected_beats.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) resample_pair(s_tdata[15:0], s_tdata[31:16]);
      if (pairs_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tdata  <= pairs_to_send.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor and scoreboard
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_beat = {m_tdata[15:0], m_tdata[31:16], m_tlast};
        if (expected_beats.size() == 0) begin
          note_mismatch("output beat with nothing expected", '0, got_beat);
        end else begin
          want_beat = expected_beats.pop_front();
          if (got_beat !== want_beat) note_mismatch("output beat mismatch", want_beat, got_beat);
        end
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: cycles without any beat or register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stereo_linear_resampler_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int          k;
    int          n;
    logic [31:0] ratio;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Upsample from a moving position; the very first pair is only held
    apb_write(STEP_RATIO_ADDR, 32'd40000);
    pairs_to_send = '{32'h7FFF_8000, 32'h8000_7FFF, 32'h0000_0000, 32'h0001_FFFF,
                      32'h7FFF_7FFF};
    drain();
    // Unity ratio passes straight through and leaves the position alone
    apb_write(STEP_RATIO_ADDR, 32'd65536);
    pairs_to_send = '{32'h8000_8000, 32'hFEDC_1234, 32'h0000_FFFF};
    drain();
    apb_write(STEP_RATIO_ADDR, 32'd8192);
    pairs_to_send = '{32'h8000_7FFF, 32'h7FFF_8000, 32'h5555_AAAA};
    drain();
    // Zero ratio: run cap hit on every pair
    apb_write(STEP_RATIO_ADDR, 32'd0);
    pairs_to_send = '{32'h0000_7FFF, 32'h8000_0000};
    drain();
    // Steepest downsample leaves the position above one for several pairs
    apb_write(STEP_RATIO_ADDR, 32'd262143);
    pairs_to_send = '{32'h1111_2222, 32'h3333_4444, 32'h7FFF_8000, 32'h8000_7FFF,
                      32'h0F0F_F0F0};
    drain();
    // Write past the register map; the ratio must hold
    apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
    pairs_to_send = '{32'h1357_2468, 32'hFFFF_0001};
    drain();

    for (k = 0; k < 8; k++) begin
      case (k)
        0:       ratio = 32'd8192;
        1:       ratio = 32'd262143;
        2:       ratio = 32'd65536;
        3:       ratio = $urandom_range(65535, 8192);
        4:       ratio = $urandom_range(262143, 65537);
        5:       ratio = 32'd71331;
        6:       ratio = $urandom_range(262143, 8192);
        default: ratio = $urandom_range(30000, 8192);
      endcase
      case (k % 4)
        0:       begin src_idle_pct = 0;  sink_idle_pct = 0;  end
        1:       begin src_idle_pct = 59; sink_idle_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_idle_pct = 59; end
        default: begin src_idle_pct = 9;  sink_idle_pct = 9;  end
      endcase
      // Upper bits of the bus are junk; only the low 18 count
      apb_write(STEP_RATIO_ADDR, ($urandom() & 32'hFFFC_0000) | ratio);
      for (n = 0; n < 44; n++) begin
        pairs_to_send.push_back(random_pair());
        // Hold the sender mid-phase until the output side has caught up
        if (k == 3 && n == 21) drain();
      end
      drain();
    end

    if (expected_beats.size() != 0)
      note_mismatch("output beat never arrived", expected_beats[0], '0);
    if (mismatches == 0)
      $display("stereo_linear_resampler_core regression: pass");
    else
      $display("stereo_linear_resampler_core regression: fail");
    $finish;
  end

endmodule
